### hw/rtl/ftra_pkg.sv
// Package for the fan tacho rpm averager.
// Holds the result status codes and the fixed constants of the datapath.
// No dependencies.
package ftra_pkg;

   localparam int CFG_W    = 16;
   localparam int DUR_W    = 16;
   localparam int STATUS_W = 2;
   localparam int RPM_W    = 20;

   localparam logic [STATUS_W-1:0] STATUS_NONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_STALL = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RPM   = 2'd2;

   localparam logic [CFG_W-1:0] TIMEOUT_RESET = 16'd2000;
   localparam logic [DUR_W-1:0] DURATION_MAX  = 16'hFFFF;

   // 60000 ms per minute times 16 for the four fraction bits; also the ceiling.
   localparam logic [RPM_W-1:0] RPM_Q4_MAX = 20'd960000;

endpackage

### hw/rtl/ftra_if.sv
// Handshake interfaces for the request and response channels.
// Depends on ftra_pkg for the payload widths.
interface ftra_req_if;
   logic valid;
   logic ready;
   logic edge_seen;

   modport source (output valid, output edge_seen, input ready);
   modport sink (input valid, input edge_seen, output ready);
endinterface

interface ftra_rsp_if;
   import ftra_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] speed_status;
   logic [RPM_W-1:0]    rpm_q4;

   modport source (output valid, output speed_status, output rpm_q4, input ready);
   modport sink (input valid, input speed_status, input rpm_q4, output ready);
endinterface

### hw/rtl/ftra_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module ftra_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/fan_tacho_rpm_averager.sv
// Fan tachometer averager. Each request beat is one millisecond tick with a
// flag for a tacho edge; each tick returns one response beat: no data, stalled
// (0 rpm), or the average speed 60000 * n / sum of the last n edge-to-edge
// durations, as unsigned Q.4 rpm saturated at 60000 rpm. In the rpm case a
// tick reads the duration ring through the single read port of its RAM and
// then runs the bit-serial divider. Write the stall timeout register only
// while no tick is in flight; it applies from the next tick on.
module fan_tacho_rpm_averager #(
   parameter int RING_DEPTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   ftra_req_if.sink                     req_bus,
   ftra_rsp_if.source                   rsp_bus,
   input  logic                         csr_wr_en,
   input  logic [ftra_pkg::CFG_W-1:0]   csr_wr_data
);
   import ftra_pkg::*;

   localparam int AW     = $clog2(RING_DEPTH);
   localparam int FC_W   = $clog2(RING_DEPTH + 1);
   localparam int SUM_W  = DUR_W + FC_W;
   localparam int NUM_W  = RPM_W + FC_W;
   localparam int CNT_W  = $clog2(NUM_W + 1);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_DECIDE  = 3'd1;
   localparam logic [2:0] ST_STALL   = 3'd2;
   localparam logic [2:0] ST_SUM     = 3'd3;
   localparam logic [2:0] ST_DIV     = 3'd4;
   localparam logic [2:0] ST_DONE    = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic [31:0]         tick_ff, tick_in;
   logic [31:0]         last_edge_ff, last_edge_in;
   logic [AW-1:0]       write_slot_ff, write_slot_in;
   logic [FC_W-1:0]     filled_ff, filled_in;
   logic                first_done_ff, first_done_in;
   logic [CFG_W-1:0]    timeout_ff, timeout_in;
   logic [FC_W-1:0]     idx_ff, idx_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [NUM_W-1:0]    num_ff, num_in;
   logic [SUM_W-1:0]    rem_ff, rem_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [RPM_W-1:0]    res_rpm_ff, res_rpm_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [RPM_W-1:0]    rsp_rpm_ff, rsp_rpm_in;

   logic                ram_wr_en;
   logic [AW-1:0]       ram_wr_addr;
   logic [DUR_W-1:0]    ram_wr_data;
   logic                ram_rd_en;
   logic [AW-1:0]       ram_rd_addr;
   logic [DUR_W-1:0]    ram_rd_data;

   logic [31:0]         now;
   logic [31:0]         since_edge;
   logic [31:0]         elapsed;
   logic [FC_W-1:0]     slot_inc;
   logic [AW-1:0]       newest;
   logic [SUM_W-1:0]    sum_acc;
   logic [SUM_W:0]      trial;
   logic [SUM_W:0]      trial_diff;
   logic                q_bit;
   logic [NUM_W-1:0]    num_shift;

   ftra_ram #(
      .WIDTH (DUR_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign now        = tick_ff + 32'd1;
   assign since_edge = now - last_edge_ff;
   assign elapsed    = tick_ff - last_edge_ff;
   assign slot_inc   = FC_W'(write_slot_ff) + FC_W'(1);
   assign sum_acc    = sum_ff + SUM_W'(ram_rd_data);

   // The newest duration sits just below the write slot, or in the last slot
   // when the pointer has wrapped on a full ring.
   always_comb begin
      if (write_slot_ff == '0) begin
         newest = (filled_ff == FC_W'(RING_DEPTH)) ? AW'(RING_DEPTH - 1) : '0;
      end else begin
         newest = write_slot_ff - AW'(1);
      end
   end

   // One restoring division step; the quotient shifts in where the dividend
   // shifts out.
   assign trial      = {rem_ff, num_ff[NUM_W-1]};
   assign trial_diff = trial - {1'b0, sum_ff};
   assign q_bit      = (trial >= {1'b0, sum_ff});
   assign num_shift  = {num_ff[NUM_W-2:0], q_bit};

   always_comb begin
      state_in      = state_ff;
      tick_in       = tick_ff;
      last_edge_in  = last_edge_ff;
      write_slot_in = write_slot_ff;
      filled_in     = filled_ff;
      first_done_in = first_done_ff;
      timeout_in    = csr_wr_en ? csr_wr_data : timeout_ff;
      idx_in        = idx_ff;
      sum_in        = sum_ff;
      num_in        = num_ff;
      rem_in        = rem_ff;
      cnt_in        = cnt_ff;
      res_status_in = res_status_ff;
      res_rpm_in    = res_rpm_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      rsp_rpm_in    = rsp_rpm_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = write_slot_ff;
      ram_wr_data   = (since_edge > 32'(DURATION_MAX)) ? DURATION_MAX : since_edge[DUR_W-1:0];
      ram_rd_en     = 1'b0;
      ram_rd_addr   = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               tick_in  = now;
               state_in = ST_DECIDE;
               if (req_bus.edge_seen) begin
                  last_edge_in  = now;
                  first_done_in = 1'b1;
                  if (first_done_ff) begin
                     ram_wr_en = 1'b1;
                     if (filled_ff != FC_W'(RING_DEPTH)) begin
                        filled_in = slot_inc;
                     end
                     write_slot_in = (slot_inc == FC_W'(RING_DEPTH)) ? '0 : slot_inc[AW-1:0];
                  end
               end
            end
         end
         ST_DECIDE: begin
            if (filled_ff == '0) begin
               res_status_in = STATUS_NONE;
               res_rpm_in    = '0;
               state_in      = ST_DONE;
            end else if (elapsed > 32'(timeout_ff)) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = newest;
               state_in    = ST_STALL;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = '0;
               idx_in      = FC_W'(1);
               sum_in      = '0;
               num_in      = NUM_W'(RPM_Q4_MAX) * NUM_W'(filled_ff);
               state_in    = ST_SUM;
            end
         end
         ST_STALL: begin
            // Collapse the history to the newest duration in slot zero.
            ram_wr_en     = 1'b1;
            ram_wr_addr   = '0;
            ram_wr_data   = ram_rd_data;
            write_slot_in = '0;
            filled_in     = FC_W'(1);
            res_status_in = STATUS_STALL;
            res_rpm_in    = '0;
            state_in      = ST_DONE;
         end
         ST_SUM: begin
            sum_in = sum_acc;
            if (idx_ff == filled_ff) begin
               if (sum_acc == '0) begin
                  res_status_in = STATUS_RPM;
                  res_rpm_in    = RPM_Q4_MAX;
                  state_in      = ST_DONE;
               end else begin
                  rem_in   = '0;
                  cnt_in   = CNT_W'(NUM_W);
                  state_in = ST_DIV;
               end
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = idx_ff[AW-1:0];
               idx_in      = idx_ff + FC_W'(1);
            end
         end
         ST_DIV: begin
            rem_in = q_bit ? trial_diff[SUM_W-1:0] : trial[SUM_W-1:0];
            num_in = num_shift;
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               res_status_in = STATUS_RPM;
               res_rpm_in    = (num_shift > NUM_W'(RPM_Q4_MAX)) ? RPM_Q4_MAX
                                                               : num_shift[RPM_W-1:0];
               state_in      = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_rpm_in    = res_rpm_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         tick_ff       <= '0;
         last_edge_ff  <= '0;
         write_slot_ff <= '0;
         filled_ff     <= '0;
         first_done_ff <= 1'b0;
         timeout_ff    <= TIMEOUT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         tick_ff       <= tick_in;
         last_edge_ff  <= last_edge_in;
         write_slot_ff <= write_slot_in;
         filled_ff     <= filled_in;
         first_done_ff <= first_done_in;
         timeout_ff    <= timeout_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      sum_ff        <= sum_in;
      num_ff        <= num_in;
      rem_ff        <= rem_in;
      cnt_ff        <= cnt_in;
      res_status_ff <= res_status_in;
      res_rpm_ff    <= res_rpm_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rpm_ff    <= rsp_rpm_in;
   end

   assign req_bus.ready        = (state_ff == ST_IDLE);
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.speed_status = rsp_status_ff;
   assign rsp_bus.rpm_q4       = rsp_rpm_ff;

endmodule

### hw/rtl/ftra_checker.sv
// Port-level checks for the fan tacho rpm averager, bound to its top level.
// Depends on ftra_pkg for the status codes and the rpm ceiling.
module ftra_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [ftra_pkg::STATUS_W-1:0] rsp_speed_status,
   input logic [ftra_pkg::RPM_W-1:0]    rsp_rpm_q4
);
   import ftra_pkg::*;

   logic [1:0] pending_ff, pending_in;
   logic       seen_data_ff, seen_data_in;
   logic       req_beat, rsp_beat;

   assign req_beat = req_valid && req_ready;
   assign rsp_beat = rsp_valid && rsp_ready;

   // Ticks taken whose response beat has not yet gone out.
   assign pending_in   = pending_ff + {1'b0, req_beat} - {1'b0, rsp_beat};
   assign seen_data_in = seen_data_ff || (rsp_beat && rsp_speed_status != STATUS_NONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= '0;
         seen_data_ff <= 1'b0;
      end else begin
         pending_ff   <= pending_in;
         seen_data_ff <= seen_data_in;
      end
   end

   a_no_orphan_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_beat |-> pending_ff != 2'd0)
      else $error("response beat without a pending tick");

   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("more than two ticks outstanding");

   a_zero_unless_rpm: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_speed_status != STATUS_RPM |-> rsp_rpm_q4 == '0)
      else $error("nonzero rpm with a no-data or stall status");

   a_rpm_ceiling: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_rpm_q4 <= RPM_Q4_MAX)
      else $error("rpm above the ceiling");

   a_data_stays: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && seen_data_ff |-> rsp_speed_status != STATUS_NONE)
      else $error("no-data status after a duration was stored");

endmodule

bind fan_tacho_rpm_averager ftra_checker u_ftra_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_speed_status (rsp_bus.speed_status),
   .rsp_rpm_q4       (rsp_bus.rpm_q4)
);
